### rtl/ipc_pkg.sv
// shared types and constants for the irrigation pump controller
`default_nettype none

package ipc_pkg;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_AUTO      = 3'd1;
  localparam logic [2:0] OP_MANUAL    = 3'd2;
  localparam logic [2:0] OP_PUMP_ON   = 3'd3;
  localparam logic [2:0] OP_PUMP_OFF  = 3'd4;
  localparam logic [2:0] OP_SET_TEMP  = 3'd5;
  localparam logic [2:0] OP_SET_SOIL  = 3'd6;
  localparam logic [2:0] OP_UNKNOWN   = 3'd7;

  localparam logic [2:0] ALARM_NONE    = 3'd0;
  localparam logic [2:0] ALARM_TIMEOUT = 3'd1;
  localparam logic [2:0] ALARM_SENSOR  = 3'd2;
  localparam logic [2:0] ALARM_TEMP    = 3'd3;
  localparam logic [2:0] ALARM_DRY     = 3'd4;

  localparam logic [1:0] REG_PUMP_LIMIT = 2'd0;
  localparam logic [1:0] REG_GRACE      = 2'd1;
  localparam logic [1:0] REG_HYST       = 2'd2;

  localparam logic [15:0] TEMP_LIM_MIN  = 16'd10;
  localparam logic [15:0] TEMP_LIM_MAX  = 16'd60;
  localparam logic [15:0] SOIL_LIM_MIN  = 16'd5;
  localparam logic [15:0] SOIL_LIM_MAX  = 16'd95;
  localparam logic [7:0]  PERCENT_FULL  = 8'd100;
  localparam logic [15:0] CNT_MAX       = 16'hFFFF;

  localparam logic [15:0] PUMP_LIMIT_RST = 16'd300;
  localparam logic [15:0] GRACE_RST      = 16'd30;
  localparam logic [6:0]  HYST_RST       = 7'd10;
  localparam logic [7:0]  TEMP_LIMIT_RST = 8'd35;
  localparam logic [6:0]  SOIL_LIMIT_RST = 7'd30;

  typedef struct packed {
    logic        is_ack;
    logic [2:0]  ack_op;
    logic [15:0] ack_value;
    logic [15:0] ack_sequence;
    logic        ack_rejected;
    logic        pump_drive;
    logic        mode_is_auto;
    logic [2:0]  alarm;
    logic        buzzer;
  } res_t;

endpackage

`default_nettype wire

### rtl/irrigation_pump_controller.sv
// irrigation pump controller: command and tick handling with two-entry result buffer
//
// channel  direction  handshake                  payload
// in_      slave      in_tvalid / in_tready      in_tuser op, in_tdata fields
// out_     master     out_tvalid / out_tready    out_tuser is_ack, out_tdata fields
// cfg_     slave      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one item per cycle while in_tready is high: state and the result are computed in the
// accept cycle; the result is registered and shows on out_ from the output register
// a skid register holds a second result so input keeps flowing while out_ stalls
// in_tready drops only while both result slots are full; cfg_ready is always high
// rst_n is synchronous, active low, and restores all limits and controller state
`default_nettype none

module irrigation_pump_controller
  import ipc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // op
  // value[15:0], ack_wanted[16], sequence_req[32:17], moisture[39:33],
  // temperature[47:40], sensor_valid[48], zero fill[55:49]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tuser,  // is_ack
  // ack_op[2:0], ack_value[18:3], ack_sequence[34:19], ack_rejected[35],
  // pump_drive[36], mode_is_auto[37], alarm[40:38], buzzer[41], zero fill[47:42]
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] pump_limit_r;
  logic [15:0] grace_r;
  logic [6:0]  hyst_r;

  logic        auto_r, auto_nxt;
  logic        pump_r, pump_nxt;
  logic        active_r, active_nxt;
  logic        latch_r, latch_nxt;
  logic [15:0] run_r, run_nxt;
  logic [15:0] uptime_r, uptime_nxt;
  logic [7:0]  temp_lim_r, temp_lim_nxt;
  logic [6:0]  soil_lim_r, soil_lim_nxt;

  res_t        out_r, skid_r, res_nxt;
  logic        out_valid_r, skid_valid_r;
  logic        has_res;

  logic [2:0]  op;
  logic [15:0] val;
  logic        want;
  logic [15:0] seq;
  logic [6:0]  soil;
  logic [7:0]  temp;
  logic        sens_ok;

  logic        in_fire, pop, push;
  logic        grace_over;
  logic [7:0]  stop_sum, stop_th;
  logic [2:0]  alarm;

  assign op      = in_tuser;
  assign val     = in_tdata[15:0];
  assign want    = in_tdata[16];
  assign seq     = in_tdata[32:17];
  assign soil    = in_tdata[39:33];
  assign temp    = in_tdata[47:40];
  assign sens_ok = in_tdata[48];

  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;
  assign push      = in_fire && has_res;

  assign stop_sum = {1'b0, soil_lim_r} + {1'b0, hyst_r};
  assign stop_th  = (stop_sum > PERCENT_FULL) ? PERCENT_FULL : stop_sum;

  always_comb begin
    auto_nxt     = auto_r;
    pump_nxt     = pump_r;
    active_nxt   = active_r;
    latch_nxt    = latch_r;
    run_nxt      = run_r;
    uptime_nxt   = uptime_r;
    temp_lim_nxt = temp_lim_r;
    soil_lim_nxt = soil_lim_r;
    grace_over   = uptime_r >= grace_r;
    alarm        = ALARM_NONE;
    res_nxt      = '0;
    has_res      = 1'b0;

    unique case (op)
      OP_TICK: begin
        has_res = 1'b1;
        if (uptime_r != CNT_MAX) begin
          uptime_nxt = uptime_r + 16'd1;
        end
        if (auto_r) begin
          if ({1'b0, soil} >= stop_th) begin
            pump_nxt  = 1'b0;
            latch_nxt = 1'b0;
          end else if (soil <= soil_lim_r && !latch_r) begin
            pump_nxt = 1'b1;
          end
        end
        if (active_r && run_r != CNT_MAX) begin
          run_nxt = run_r + 16'd1;
        end
        // timer restarts only from idle; a tick with the pump off idles it
        if (pump_nxt && !active_r) begin
          active_nxt = 1'b1;
          run_nxt    = '0;
        end else if (!pump_nxt) begin
          active_nxt = 1'b0;
        end
        if (pump_nxt && run_nxt >= pump_limit_r) begin
          pump_nxt  = 1'b0;
          latch_nxt = 1'b1;
        end
        if (latch_nxt) begin
          alarm = ALARM_TIMEOUT;
        end else if (grace_over && !sens_ok) begin
          alarm = ALARM_SENSOR;
        end else if (temp >= temp_lim_r) begin
          alarm = ALARM_TEMP;
        end else if (soil <= soil_lim_r) begin
          alarm = ALARM_DRY;
        end
        res_nxt.pump_drive   = pump_nxt;
        res_nxt.mode_is_auto = auto_r;
        res_nxt.alarm        = alarm;
        res_nxt.buzzer       = alarm != ALARM_NONE;
      end
      OP_AUTO: begin
        auto_nxt          = 1'b1;
        latch_nxt         = 1'b0;
        res_nxt.ack_value = 16'd1;
      end
      OP_MANUAL: begin
        auto_nxt  = 1'b0;
        pump_nxt  = 1'b0;
        latch_nxt = 1'b0;
      end
      OP_PUMP_ON, OP_PUMP_OFF: begin
        if (!auto_r) begin
          pump_nxt = op == OP_PUMP_ON;
        end else begin
          res_nxt.ack_rejected = 1'b1;
        end
        res_nxt.ack_value = {15'd0, pump_nxt};
      end
      OP_SET_TEMP: begin
        if (val >= TEMP_LIM_MIN && val <= TEMP_LIM_MAX) begin
          temp_lim_nxt = val[7:0];
        end else begin
          res_nxt.ack_rejected = 1'b1;
        end
        res_nxt.ack_value = {8'd0, temp_lim_nxt};
      end
      OP_SET_SOIL: begin
        if (val >= SOIL_LIM_MIN && val <= SOIL_LIM_MAX) begin
          soil_lim_nxt = val[6:0];
        end else begin
          res_nxt.ack_rejected = 1'b1;
        end
        res_nxt.ack_value = {9'd0, soil_lim_nxt};
      end
      OP_UNKNOWN: begin
        res_nxt.ack_rejected = 1'b1;
      end
      default: begin
        res_nxt.ack_rejected = 1'b1;
      end
    endcase

    if (op != OP_TICK) begin
      has_res              = want;
      res_nxt.is_ack       = 1'b1;
      res_nxt.ack_op       = op;
      res_nxt.ack_sequence = seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_limit_r <= PUMP_LIMIT_RST;
      grace_r      <= GRACE_RST;
      hyst_r       <= HYST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PUMP_LIMIT: pump_limit_r <= cfg_data;
        REG_GRACE:      grace_r      <= cfg_data;
        REG_HYST:       hyst_r       <= cfg_data[6:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r     <= 1'b0;
      pump_r     <= 1'b0;
      active_r   <= 1'b0;
      latch_r    <= 1'b0;
      run_r      <= '0;
      uptime_r   <= '0;
      temp_lim_r <= TEMP_LIMIT_RST;
      soil_lim_r <= SOIL_LIMIT_RST;
    end else if (in_fire) begin
      auto_r     <= auto_nxt;
      pump_r     <= pump_nxt;
      active_r   <= active_nxt;
      latch_r    <= latch_nxt;
      run_r      <= run_nxt;
      uptime_r   <= uptime_nxt;
      temp_lim_r <= temp_lim_nxt;
      soil_lim_r <= soil_lim_nxt;
    end
  end

  // two result slots: output register first, skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (push) begin
      skid_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.is_ack;
  assign out_tdata  = {6'd0, out_r.buzzer, out_r.alarm, out_r.mode_is_auto,
                       out_r.pump_drive, out_r.ack_rejected, out_r.ack_sequence,
                       out_r.ack_value, out_r.ack_op};

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while the output slot is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");

  a_buzzer_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.is_ack |-> out_r.buzzer == (out_r.alarm != ALARM_NONE))
    else $error("buzzer does not follow alarm");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_tready |=> skid_valid_r && $stable(skid_r))
    else $error("skid result lost while output stalled");
`endif

endmodule

`default_nettype wire

### bench/irrigation_pump_controller_test.sv
// self-checking testbench for the irrigation pump controller
module irrigation_pump_controller_test
  import ipc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int IDLE_PCT = 28;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic [6:0]  fill;
    logic        sensor_valid;
    logic [7:0]  temperature;
    logic [6:0]  moisture;
    logic [15:0] sequence_req;
    logic        ack_wanted;
    logic [15:0] value;
  } in_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = OP_TICK;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;
  logic [47:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_PUMP_LIMIT;
  logic [15:0] cfg_data = '0;

  irrigation_pump_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // controller shadow: registers and state
  logic [15:0] cfg_pump_limit = PUMP_LIMIT_RST;
  logic [15:0] cfg_grace = GRACE_RST;
  logic [6:0]  cfg_hyst = HYST_RST;
  logic        st_auto = 1'b0;
  logic        st_pump = 1'b0;
  logic        st_run_active = 1'b0;
  logic        st_timeout = 1'b0;
  logic [15:0] st_run_ticks = '0;
  logic [15:0] st_uptime = '0;
  logic [7:0]  st_temp_limit = TEMP_LIMIT_RST;
  logic [6:0]  st_soil_limit = SOIL_LIMIT_RST;

  res_t expected_results[$];
  int   errors = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   acks_seen = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  bit   idle_on = 1'b1;

  task automatic predict_response(input logic [2:0] op, input in_word_t w);
    res_t        r;
    logic        grace_over;
    logic [7:0]  stop;
    logic        ok;
    logic [15:0] actual;
    logic [2:0]  alarm;
    r = '0;
    if (op == OP_TICK) begin
      grace_over = (st_uptime >= cfg_grace);
      if (st_uptime != CNT_MAX) st_uptime = st_uptime + 16'd1;
      if (st_auto) begin
        stop = {1'b0, st_soil_limit} + {1'b0, cfg_hyst};
        if (stop > PERCENT_FULL) stop = PERCENT_FULL;
        if ({1'b0, w.moisture} >= stop) begin
          st_pump = 1'b0;
          st_timeout = 1'b0;
        end else if (w.moisture <= st_soil_limit && !st_timeout) begin
          st_pump = 1'b1;
        end
      end
      if (st_run_active && st_run_ticks != CNT_MAX) st_run_ticks = st_run_ticks + 16'd1;
      if (st_pump && !st_run_active) begin
        st_run_active = 1'b1;
        st_run_ticks = '0;
      end else if (!st_pump) begin
        st_run_active = 1'b0;
      end
      if (st_pump && st_run_ticks >= cfg_pump_limit) begin
        st_pump = 1'b0;
        st_timeout = 1'b1;
      end
      if (st_timeout) alarm = ALARM_TIMEOUT;
      else if (grace_over && !w.sensor_valid) alarm = ALARM_SENSOR;
      else if (w.temperature >= st_temp_limit) alarm = ALARM_TEMP;
      else if (w.moisture <= st_soil_limit) alarm = ALARM_DRY;
      else alarm = ALARM_NONE;
      r.pump_drive = st_pump;
      r.mode_is_auto = st_auto;
      r.alarm = alarm;
      r.buzzer = (alarm != ALARM_NONE);
      expected_results.push_back(r);
    end else begin
      ok = 1'b1;
      actual = '0;
      case (op)
        OP_AUTO: begin
          st_auto = 1'b1;
          st_timeout = 1'b0;
          actual = 16'd1;
        end
        OP_MANUAL: begin
          st_auto = 1'b0;
          st_pump = 1'b0;
          st_timeout = 1'b0;
        end
        OP_PUMP_ON, OP_PUMP_OFF: begin
          if (!st_auto) st_pump = (op == OP_PUMP_ON);
          else ok = 1'b0;
          actual = {15'd0, st_pump};
        end
        OP_SET_TEMP: begin
          if (w.value >= TEMP_LIM_MIN && w.value <= TEMP_LIM_MAX) st_temp_limit = w.value[7:0];
          else ok = 1'b0;
          actual = {8'd0, st_temp_limit};
        end
        OP_SET_SOIL: begin
          if (w.value >= SOIL_LIM_MIN && w.value <= SOIL_LIM_MAX) st_soil_limit = w.value[6:0];
          else ok = 1'b0;
          actual = {9'd0, st_soil_limit};
        end
        default: begin
          ok = 1'b0;
        end
      endcase
      if (w.ack_wanted) begin
        r.is_ack = 1'b1;
        r.ack_op = op;
        r.ack_value = actual;
        r.ack_sequence = w.sequence_req;
        r.ack_rejected = !ok;
        expected_results.push_back(r);
      end
    end
  endtask

  function automatic in_word_t make_word(input logic [15:0] value, input logic ack,
                                         input logic [6:0] soil, input logic [7:0] temp,
                                         input logic valid);
    in_word_t w;
    w = '0;
    w.value = value;
    w.ack_wanted = ack;
    w.sequence_req = 16'($urandom);
    w.moisture = soil;
    w.temperature = temp;
    w.sensor_valid = valid;
    return w;
  endfunction

  task automatic send_item(input logic [2:0] op, input in_word_t w);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    predict_response(op, w);
    items_sent++;
  endtask

  task automatic tick(input logic [6:0] soil, input logic [7:0] temp, input logic valid);
    send_item(OP_TICK, make_word(16'($urandom), 1'($urandom), soil, temp, valid));
  endtask

  task automatic command(input logic [2:0] op, input logic [15:0] value, input logic ack);
    send_item(op, make_word(value, ack, 7'($urandom), 8'($urandom), 1'($urandom)));
  endtask

  // also used as the sender pause: nothing offered until every result is back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PUMP_LIMIT: cfg_pump_limit = data;
      REG_GRACE:      cfg_grace = data;
      REG_HYST:       cfg_hyst = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_power_on();
    // still inside the grace window, so an invalid sensor raises nothing
    tick(7'd100, 8'd0, 1'b0);
    tick(7'd0, 8'd255, 1'b1);
    tick(7'd127, 8'd34, 1'b1);
    tick(7'd30, 8'd34, 1'b1);
  endtask

  task automatic test_commands();
    command(OP_UNKNOWN, 16'hFFFF, 1'b1);
    command(OP_SET_TEMP, 16'd9, 1'b1);
    command(OP_SET_TEMP, 16'd10, 1'b1);
    command(OP_SET_TEMP, 16'd60, 1'b1);
    command(OP_SET_TEMP, 16'hFFFF, 1'b1);
    command(OP_SET_SOIL, 16'd4, 1'b1);
    command(OP_SET_SOIL, 16'd5, 1'b1);
    command(OP_SET_SOIL, 16'd96, 1'b1);
    command(OP_SET_SOIL, 16'd95, 1'b1);
    command(OP_AUTO, 16'd0, 1'b1);
    command(OP_PUMP_ON, 16'd0, 1'b1);
    command(OP_MANUAL, 16'd0, 1'b0);
    command(OP_PUMP_ON, 16'd0, 1'b1);
    command(OP_PUMP_OFF, 16'd0, 1'b1);
  endtask

  task automatic test_run_limit();
    // zero limit: pump trips on the very tick that starts its timer
    write_reg(REG_PUMP_LIMIT, 16'd0);
    command(OP_PUMP_ON, 16'd0, 1'b1);
    tick(7'd50, 8'd20, 1'b1);
    command(OP_AUTO, 16'd0, 1'b1);
  endtask

  task automatic test_hysteresis();
    // soil limit 95 plus a huge hysteresis clamps the stop point at full scale
    write_reg(REG_PUMP_LIMIT, 16'd65535);
    write_reg(REG_HYST, 16'd127);
    tick(7'd90, 8'd20, 1'b1);
    tick(7'd99, 8'd20, 1'b1);
    tick(7'd100, 8'd20, 1'b1);
  endtask

  task automatic test_grace();
    write_reg(REG_GRACE, 16'd0);
    tick(7'd60, 8'd20, 1'b0);
    write_reg(REG_GRACE, 16'd65535);
    tick(7'd60, 8'd20, 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    wait_idle();
    hold_left = 150;
    for (i = 0; i < 16; i++) tick(7'($urandom_range(100)), 8'($urandom), 1'b1);
    wait_idle();
  endtask

  task automatic random_item();
    int          pick;
    logic [2:0]  op;
    logic [15:0] value;
    logic [6:0]  soil;
    logic [7:0]  temp;
    pick = $urandom_range(99);
    soil = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    temp = ($urandom_range(3) == 0) ? 8'($urandom)
                                   : 8'(st_temp_limit + $urandom_range(8) - 4);
    if (pick < 55) begin
      tick(soil, temp, $urandom_range(99) < 85);
    end else begin
      case ($urandom_range(11))
        0, 1:    op = OP_AUTO;
        2, 3:    op = OP_MANUAL;
        4, 5:    op = OP_PUMP_ON;
        6:       op = OP_PUMP_OFF;
        7, 8:    op = OP_SET_TEMP;
        9, 10:   op = OP_SET_SOIL;
        default: op = OP_UNKNOWN;
      endcase
      if ($urandom_range(1) == 0) value = 16'($urandom);
      else if (op == OP_SET_TEMP)
        value = 16'($urandom_range(TEMP_LIM_MAX + 1, TEMP_LIM_MIN - 1));
      else value = 16'($urandom_range(SOIL_LIM_MAX + 1, SOIL_LIM_MIN - 1));
      send_item(op, make_word(value, $urandom_range(99) < 80, soil, temp, 1'($urandom)));
    end
  endtask

  task automatic test_random(input int phase, input int count);
    int i;
    case (phase)
      0: begin
        write_reg(REG_PUMP_LIMIT, 16'd65535);
        write_reg(REG_GRACE, 16'd30);
        write_reg(REG_HYST, 16'd0);
      end
      1: begin
        write_reg(REG_PUMP_LIMIT, 16'd1);
        write_reg(REG_GRACE, 16'd0);
        write_reg(REG_HYST, 16'd100);
      end
      default: begin
        write_reg(REG_PUMP_LIMIT, 16'($urandom_range(12)));
        write_reg(REG_GRACE,
                  ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(400)));
        write_reg(REG_HYST, 16'($urandom_range(127)));
      end
    endcase
    for (i = 0; i < count; i++) random_item();
  endtask

  // result side: random ready, with a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_ack = out_tuser;
      got.ack_op = out_tdata[2:0];
      got.ack_value = out_tdata[18:3];
      got.ack_sequence = out_tdata[34:19];
      got.ack_rejected = out_tdata[35];
      got.pump_drive = out_tdata[36];
      got.mode_is_auto = out_tdata[37];
      got.alarm = out_tdata[40:38];
      got.buzzer = out_tdata[41];
      results_seen++;
      if (got.is_ack) acks_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t: tuser=%0d tdata=%h",
                                   $realtime, out_tuser, out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display({"  expected ack=%0d op=%0d val=%0d seq=%0d rej=%0d",
                      " pump=%0d auto=%0d alarm=%0d buz=%0d"},
                     want.is_ack, want.ack_op, want.ack_value, want.ack_sequence,
                     want.ack_rejected, want.pump_drive, want.mode_is_auto, want.alarm,
                     want.buzzer);
            $display({"  actual   ack=%0d op=%0d val=%0d seq=%0d rej=%0d",
                      " pump=%0d auto=%0d alarm=%0d buz=%0d"},
                     got.is_ack, got.ack_op, got.ack_value, got.ack_sequence,
                     got.ack_rejected, got.pump_drive, got.mode_is_auto, got.alarm,
                     got.buzzer);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, expected_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_power_on();
    test_commands();
    test_run_limit();
    test_hysteresis();
    test_grace();
    test_backpressure();
    // first random phase runs with no idling on either side
    idle_on = 1'b0;
    test_random(0, 100);
    idle_on = 1'b1;
    for (phase = 1; phase < 5; phase++) test_random(phase, 110);
    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d items and %0d results (%0d acks) over directed, hold-off and",
             items_sent, results_seen, acks_seen);
    $display("five random register settings; %0d mismatches", errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
